FILE: rtl/core/hlfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfr_pkg: header/length frame receiver package
// Shared types and constants for the frame receiver.
// ----------------------------------------------------------------------------
package hlfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 6;
  localparam int unsigned GapW  = 4;
  localparam int unsigned OpW   = 2;
  localparam int unsigned IdxW  = 3;

  localparam logic [ByteW-1:0] Hdr0     = 8'hA5;
  localparam logic [ByteW-1:0] Hdr1     = 8'hB4;
  localparam logic [ByteW-1:0] Bcast    = 8'hFF;
  localparam logic [PosW-1:0]  LenShort = 6'd6;
  localparam logic [PosW-1:0]  LenAddr  = 6'd7;
  localparam logic [PosW-1:0]  LenParam = 6'd38;
  localparam logic [PosW-1:0]  LenOther = 6'd7;
  localparam logic [PosW-1:0]  PosAddr  = 6'd2;
  localparam logic [PosW-1:0]  PosCmd   = 6'd3;
  localparam logic [PosW-1:0]  PosHdr1  = 6'd1;

  typedef enum logic [OpW-1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RELEASE = 2'd2
  } hlfr_op_e;

  typedef enum logic [IdxW-1:0] {
    REG_STOP    = 3'd0,
    REG_START   = 3'd1,
    REG_ADDRESS = 3'd2,
    REG_PARAM   = 3'd3,
    REG_GAP     = 3'd4
  } hlfr_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] stop_code;
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] address_code;
    logic [ByteW-1:0] param_code;
    logic [GapW-1:0]  gap_ticks;
  } hlfr_cfg_t;

  typedef struct packed {
    logic             frame_pending;
    logic [PosW-1:0]  write_position;
    logic [PosW-1:0]  expected_length;
    logic [GapW-1:0]  gap_counter;
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] address_byte;
  } hlfr_state_t;

  typedef struct packed {
    logic             stored;
    logic [PosW-1:0]  position;
    logic [ByteW-1:0] byte_out;
    logic             frame_done;
    logic [PosW-1:0]  frame_length;
    logic             dropped;
  } hlfr_result_t;

endpackage

FILE: rtl/core/hlfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfr_if: frame receiver channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface hlfr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface hlfr_rsp_if;
  logic       valid;
  logic       ready;
  logic       stored;
  logic [5:0] position;
  logic [7:0] byte_out;
  logic       frame_done;
  logic [5:0] frame_length;
  logic       dropped;

  modport source (
    output valid, output stored, output position, output byte_out,
    output frame_done, output frame_length, output dropped, input ready
  );
  modport sink (
    input valid, input stored, input position, input byte_out,
    input frame_done, input frame_length, input dropped, output ready
  );
endinterface

FILE: rtl/core/hlfr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfr_cfg: configuration registers
// Command codes and gap reload value, written through a plain write port.
// ----------------------------------------------------------------------------
module hlfr_cfg
  import hlfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_idx_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  output hlfr_cfg_t        cfg_o
);

  hlfr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STOP:    cfg_d.stop_code    = cfg_wdata_i;
        REG_START:   cfg_d.start_code   = cfg_wdata_i;
        REG_ADDRESS: cfg_d.address_code = cfg_wdata_i;
        REG_PARAM:   cfg_d.param_code   = cfg_wdata_i;
        REG_GAP:     cfg_d.gap_ticks    = cfg_wdata_i[GapW-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_code    <= 8'd0;
      cfg_q.start_code   <= 8'd1;
      cfg_q.address_code <= 8'd2;
      cfg_q.param_code   <= 8'd3;
      cfg_q.gap_ticks    <= 4'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/hlfr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfr_step: frame receiver update logic
// Next receiver state and the result for one transaction.
// ----------------------------------------------------------------------------
module hlfr_step
  import hlfr_pkg::*;
(
  input  logic [OpW-1:0]   op_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  hlfr_cfg_t        cfg_i,
  input  hlfr_state_t      state_i,
  output hlfr_state_t      state_o,
  output hlfr_result_t     result_o
);

  function automatic logic [PosW-1:0] pick_length(
    input logic [ByteW-1:0] cmd,
    input logic [ByteW-1:0] addr,
    input hlfr_cfg_t        cfg
  );
    logic bc;
    bc = (addr == Bcast);
    if (cmd == cfg.stop_code && bc)         return LenShort;
    else if (cmd == cfg.start_code && bc)   return LenShort;
    else if (cmd == cfg.address_code && bc) return LenAddr;
    else if (cmd == cfg.param_code)         return LenParam;
    else                                    return LenOther;
  endfunction

  logic [PosW-1:0]  pos;
  logic [PosW:0]    pos_inc;
  logic [ByteW-1:0] first_b;
  logic [ByteW-1:0] addr_b;
  logic [PosW-1:0]  len_n;

  always_comb begin
    pos = state_i.write_position;
    if (pos >= state_i.expected_length && state_i.expected_length != '0) begin
      pos = '0;
    end
    if (state_i.gap_counter == '0) begin
      pos = '0;
    end
    pos_inc = {1'b0, pos} + 7'd1;
    first_b = (pos == '0) ? rx_byte_i : state_i.first_byte;
    addr_b  = (pos == PosAddr) ? rx_byte_i : state_i.address_byte;
    len_n   = (pos == PosCmd) ? pick_length(rx_byte_i, addr_b, cfg_i)
                              : state_i.expected_length;
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (hlfr_op_e'(op_i))
      OP_TICK: begin
        if (state_i.gap_counter != '0) begin
          state_o.gap_counter = state_i.gap_counter - 4'd1;
        end
      end
      OP_RELEASE: begin
        if (state_i.frame_pending) begin
          state_o.frame_pending  = 1'b0;
          state_o.write_position = '0;
          state_o.first_byte     = '0;
          state_o.address_byte   = '0;
        end
      end
      OP_BYTE: begin
        if (state_i.frame_pending) begin
          result_o.dropped = 1'b1;
        end else begin
          state_o.gap_counter  = cfg_i.gap_ticks;
          state_o.first_byte   = first_b;
          state_o.address_byte = addr_b;
          result_o.stored      = 1'b1;
          result_o.position    = pos;
          result_o.byte_out    = rx_byte_i;
          if (first_b != Hdr0) begin
            state_o.write_position = '0;
          end else if (pos == PosHdr1 && rx_byte_i != Hdr1) begin
            state_o.write_position = '0;
          end else begin
            state_o.expected_length = len_n;
            if (pos > PosCmd && pos_inc == {1'b0, len_n}) begin
              state_o.frame_pending  = 1'b1;
              state_o.write_position = '0;
              result_o.frame_done    = 1'b1;
            end else begin
              state_o.write_position = pos_inc[PosW-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    result_o.frame_length = state_o.expected_length;
  end

endmodule

FILE: rtl/core/header_length_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_length_frame_receiver: header/length frame receiver
// The result of an accepted transaction is registered in the following cycle.
// Throughput: one transaction per cycle while no held result stalls input.
// A pending result that is not taken stalls input only while it is held.
// Reset clears state, presets INITIAL_LENGTH, loads code and gap defaults.
// ----------------------------------------------------------------------------
module header_length_frame_receiver
  import hlfr_pkg::*;
#(
  parameter int unsigned INITIAL_LENGTH = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  hlfr_req_if.sink         req_i,
  hlfr_rsp_if.source       rsp_o,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_idx_i,
  input  logic [ByteW-1:0] cfg_wdata_i
);

  hlfr_cfg_t    cfg;
  hlfr_state_t  state_q, state_n, state_d;
  hlfr_result_t res_n, res_q;
  logic         rsp_valid_q, rsp_valid_d;
  logic         accept;

  hlfr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hlfr_step u_step (
    .op_i      (req_i.operation),
    .rx_byte_i (req_i.rx_byte),
    .cfg_i     (cfg),
    .state_i   (state_q),
    .state_o   (state_n),
    .result_o  (res_n)
  );

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign state_d     = accept ? state_n : state_q;
  assign rsp_valid_d = accept || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.frame_pending   <= 1'b0;
      state_q.write_position  <= '0;
      state_q.expected_length <= PosW'(INITIAL_LENGTH);
      state_q.gap_counter     <= '0;
      state_q.first_byte      <= '0;
      state_q.address_byte    <= '0;
      rsp_valid_q             <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_n;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.stored       = res_q.stored;
  assign rsp_o.position     = res_q.position;
  assign rsp_o.byte_out     = res_q.byte_out;
  assign rsp_o.frame_done   = res_q.frame_done;
  assign rsp_o.frame_length = res_q.frame_length;
  assign rsp_o.dropped      = res_q.dropped;

  a_pending_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.frame_pending |-> state_q.write_position == '0)
    else $error("write position not zero while a frame is pending");

  a_done_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_n.frame_done |=> state_q.frame_pending)
    else $error("completed frame did not become pending");

  a_drop_only_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_n.dropped |-> state_q.frame_pending && !res_n.stored)
    else $error("byte dropped without a pending frame");

  a_length_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.expected_length >= LenShort)
    else $error("expected length below the shortest frame");

endmodule
